// File: rtl/wavhp_pkg.sv
// shared types, tags and status codes of the wav header parser
package wavhp_pkg;

  localparam logic [31:0] TAG_FMT     = 32'h666D7420;
  localparam logic [31:0] TAG_DATA    = 32'h64617461;
  localparam logic [7:0]  PCM_TAG     = 8'h01;
  localparam logic [31:0] WALK_START  = 32'd12;
  localparam logic [31:0] TAG_END_POS = 32'd11;
  localparam logic [31:0] POS_MAX     = 32'hFFFFFFFF;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_NOT_WAVE = 3'd2,
    ST_TRUNC    = 3'd3,
    ST_NON_PCM  = 3'd4,
    ST_BAD_BITS = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] sample_rate;
    logic [15:0] channel_count;
    logic [15:0] sample_bits;
    logic        sample_format;
    logic [31:0] payload_size;
    logic [31:0] payload_offset;
  } result_t;

  function automatic logic [7:0] riff_tag_byte(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = 8'h52;
      2'd1:    r = 8'h49;
      2'd2:    r = 8'h46;
      default: r = 8'h46;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] wave_tag_byte(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = 8'h57;
      2'd1:    r = 8'h41;
      2'd2:    r = 8'h56;
      default: r = 8'h45;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/wav_header_chunk_parser.sv
// top level of the riff/wave header parser
//
// Bytes of a WAV buffer enter on the input channel (in_valid/in_ready with
// data_byte and last_byte), one transaction per byte; last_byte marks the
// final byte of a buffer, after which the parser starts over for the next one.
// Each buffer yields exactly one result transaction on the output channel
// (out_valid/out_ready): an error status as soon as it is found, or ok once
// the riff extent is reached, carrying the fmt fields and data chunk info.
// Bytes after a report are consumed silently until last_byte.
// Throughput is one byte per cycle while the result register is free: the
// whole per-byte step is one pass of compares, a 32-bit offset subtract and
// a length compare between the input register and the result register.
// A result passes through the input register, then the result register;
// out_valid rises when the result is loaded, once that register is free.
// If the receiver stalls, the result register holds its result; the input
// register still takes one more byte, then in_ready drops until the result
// is taken.
// Synchronous reset clears both stages and the parse state to the start of a
// buffer.
module wav_header_chunk_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [31:0] sample_rate,
  output logic [15:0] channel_count,
  output logic [15:0] sample_bits,
  output logic        sample_format,
  output logic [31:0] payload_size,
  output logic [31:0] payload_offset
);
  import wavhp_pkg::*;

  item_t   in_item, held_item;
  logic    held_valid, take, free, res_valid;
  result_t res, res_q;

  assign in_item.data_byte = data_byte;
  assign in_item.last_byte = last_byte;
  assign take = held_valid && free;

  wavhp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .take       (take),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  wavhp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (take),
    .item      (held_item),
    .res_valid (res_valid),
    .res       (res)
  );

  wavhp_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (take && res_valid),
    .res_in    (res),
    .out_ready (out_ready),
    .free      (free),
    .out_valid (out_valid),
    .res_q     (res_q)
  );

  assign status         = res_q.status;
  assign sample_rate    = res_q.sample_rate;
  assign channel_count  = res_q.channel_count;
  assign sample_bits    = res_q.sample_bits;
  assign sample_format  = res_q.sample_format;
  assign payload_size   = res_q.payload_size;
  assign payload_offset = res_q.payload_offset;

  // an ok result always has a supported depth and the matching format
  a_ok_depth: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OK |->
      (sample_bits == 16'd8 && !sample_format) || (sample_bits == 16'd16 && sample_format))
    else $error("ok result with unsupported bit depth or wrong format");

  a_err_format: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> !sample_format)
    else $error("error result with sample_format set");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !held_valid)
    else $error("stages not empty after reset");

  a_held_keeps: assert property (@(posedge clk) disable iff (rst)
    held_valid && !take |=> held_valid && $stable(held_item))
    else $error("stalled input byte lost or overwritten");

endmodule

// File: rtl/wavhp_in_reg.sv
// input register stage holding one byte transaction
module wavhp_in_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  wavhp_pkg::item_t in_item,
  input  logic            take,
  output logic            held_valid,
  output wavhp_pkg::item_t held_item
);
  import wavhp_pkg::*;

  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule

// File: rtl/wavhp_parser.sv
// parse state and the per-byte step of the riff/wave walk
module wavhp_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  wavhp_pkg::item_t  item,
  output logic              res_valid,
  output wavhp_pkg::result_t res
);
  import wavhp_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_BADTAG = 3'b010,
    PH_WALK   = 3'b100
  } phase_t;

  phase_t      phase, phase_next;
  logic [31:0] byte_position, byte_position_next;
  logic [31:0] riff_extent, riff_extent_next;
  logic [31:0] chunk_begin, chunk_begin_next;
  logic [31:0] chunk_tag, chunk_tag_next;
  logic [31:0] chunk_length, chunk_length_next;
  logic [31:0] rate_reg, rate_reg_next;
  logic [15:0] channels_reg, channels_reg_next;
  logic [15:0] bits_reg, bits_reg_next;
  logic [31:0] data_size_reg, data_size_reg_next;
  logic [31:0] data_offset_reg, data_offset_reg_next;
  logic        reported, reported_next;

  // values after this byte, before the end-of-buffer clear
  phase_t      phase_upd;
  logic [31:0] extent_upd, begin_upd, tag_upd, len_upd;
  logic [31:0] rate_upd, size_upd, offset_upd;
  logic [15:0] channels_upd, bits_upd;

  logic [7:0]  b;
  logic [31:0] p, off, off_w;
  logic [32:0] ext_sum;
  logic [31:0] ext_sat;
  logic        boundary, fmt_err, emit, mismatch;
  status_t     code_raw, code;
  logic        fmt_bit;

  assign b = item.data_byte;
  assign p = byte_position;

  always_comb begin
    phase_upd    = phase;
    extent_upd   = riff_extent;
    begin_upd    = chunk_begin;
    tag_upd      = chunk_tag;
    len_upd      = chunk_length;
    rate_upd     = rate_reg;
    channels_upd = channels_reg;
    bits_upd     = bits_reg;
    size_upd     = data_size_reg;
    offset_upd   = data_offset_reg;
    emit         = 1'b0;
    code_raw     = ST_OK;
    fmt_err      = 1'b0;
    mismatch     = 1'b0;
    ext_sum      = {1'b0, riff_extent} + 33'd8;
    ext_sat      = ext_sum[32] ? POS_MAX : ext_sum[31:0];
    off          = p - chunk_begin;
    boundary     = (off >= 32'd8) && ({1'b0, off} == ({1'b0, chunk_length} + 33'd8));
    off_w        = boundary ? 32'd0 : off;

    if (!reported) begin
      if (p < 32'd4) begin
        if (b != riff_tag_byte(p[1:0])) phase_upd = PH_BADTAG;
      end else if (p < 32'd8) begin
        extent_upd[{p[1:0], 3'b000} +: 8] = b;
      end else if (p < WALK_START) begin
        mismatch = (b != wave_tag_byte(p[1:0]));
        if (mismatch) phase_upd = PH_BADTAG;
        if (p == TAG_END_POS) begin
          if (phase == PH_BADTAG || mismatch) begin
            emit     = 1'b1;
            code_raw = ST_NOT_WAVE;
          end else begin
            extent_upd = ext_sat;
            phase_upd  = PH_WALK;
            if (ext_sat <= WALK_START) emit = 1'b1;
          end
        end
      end else if (phase == PH_WALK) begin
        if (boundary) begin_upd = p;
        if (off_w == 32'd0) begin
          tag_upd = 32'd0;
          len_upd = 32'd0;
        end
        if (off_w < 32'd4) begin
          tag_upd = {tag_upd[23:0], b};
        end else if (off_w < 32'd8) begin
          len_upd[{off_w[1:0], 3'b000} +: 8] = b;
          if (off_w == 32'd7 && tag_upd == TAG_DATA) begin
            size_upd   = len_upd;
            offset_upd = begin_upd + 32'd8;
          end
        end else if (tag_upd == TAG_FMT) begin
          if (off_w == 32'd8) begin
            fmt_err = (b != PCM_TAG);
          end else if (off_w == 32'd9) begin
            fmt_err = (b != 8'd0);
          end else if (off_w inside {32'd10, 32'd11}) begin
            channels_upd[{off_w[0], 3'b000} +: 8] = b;
          end else if (off_w inside {[32'd12:32'd15]}) begin
            rate_upd[{off_w[1:0], 3'b000} +: 8] = b;
          end else if (off_w inside {32'd22, 32'd23}) begin
            bits_upd[{off_w[0], 3'b000} +: 8] = b;
          end
        end
        if (fmt_err) begin
          emit     = 1'b1;
          code_raw = ST_NON_PCM;
        end else if (({1'b0, p} + 33'd1) >= {1'b0, extent_upd}) begin
          emit = 1'b1;
        end
      end
      if (!emit && item.last_byte) begin
        emit     = 1'b1;
        code_raw = (p < TAG_END_POS) ? ST_SHORT : ST_TRUNC;
      end
    end

    // success needs a supported bit depth
    code    = code_raw;
    fmt_bit = 1'b0;
    if (code_raw == ST_OK) begin
      if (bits_upd == 16'd8) begin
        fmt_bit = 1'b0;
      end else if (bits_upd == 16'd16) begin
        fmt_bit = 1'b1;
      end else begin
        code = ST_BAD_BITS;
      end
    end
  end

  always_comb begin
    res_valid          = emit;
    res.status         = code;
    res.sample_rate    = rate_upd;
    res.channel_count  = channels_upd;
    res.sample_bits    = bits_upd;
    res.sample_format  = fmt_bit;
    res.payload_size   = size_upd;
    res.payload_offset = offset_upd;
  end

  always_comb begin
    if (item.last_byte) begin
      phase_next           = PH_HEADER;
      byte_position_next   = 32'd0;
      riff_extent_next     = 32'd0;
      chunk_begin_next     = WALK_START;
      chunk_tag_next       = 32'd0;
      chunk_length_next    = 32'd0;
      rate_reg_next        = 32'd0;
      channels_reg_next    = 16'd0;
      bits_reg_next        = 16'd0;
      data_size_reg_next   = 32'd0;
      data_offset_reg_next = 32'd0;
      reported_next        = 1'b0;
    end else begin
      phase_next           = phase_upd;
      byte_position_next   = (reported || p == POS_MAX) ? p : p + 32'd1;
      riff_extent_next     = extent_upd;
      chunk_begin_next     = begin_upd;
      chunk_tag_next       = tag_upd;
      chunk_length_next    = len_upd;
      rate_reg_next        = rate_upd;
      channels_reg_next    = channels_upd;
      bits_reg_next        = bits_upd;
      data_size_reg_next   = size_upd;
      data_offset_reg_next = offset_upd;
      reported_next        = reported || emit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      byte_position   <= 32'd0;
      riff_extent     <= 32'd0;
      chunk_begin     <= WALK_START;
      chunk_tag       <= 32'd0;
      chunk_length    <= 32'd0;
      rate_reg        <= 32'd0;
      channels_reg    <= 16'd0;
      bits_reg        <= 16'd0;
      data_size_reg   <= 32'd0;
      data_offset_reg <= 32'd0;
      reported        <= 1'b0;
    end else if (step) begin
      phase           <= phase_next;
      byte_position   <= byte_position_next;
      riff_extent     <= riff_extent_next;
      chunk_begin     <= chunk_begin_next;
      chunk_tag       <= chunk_tag_next;
      chunk_length    <= chunk_length_next;
      rate_reg        <= rate_reg_next;
      channels_reg    <= channels_reg_next;
      bits_reg        <= bits_reg_next;
      data_size_reg   <= data_size_reg_next;
      data_offset_reg <= data_offset_reg_next;
      reported        <= reported_next;
    end
  end

endmodule

// File: rtl/wavhp_out_reg.sv
// result register in front of the output channel
module wavhp_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  wavhp_pkg::result_t res_in,
  input  logic               out_ready,
  output logic               free,
  output logic               out_valid,
  output wavhp_pkg::result_t res_q
);
  import wavhp_pkg::*;

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      res_q <= res_in;
    end
  end

endmodule
